FILE: hw/rtl/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg
// Shared types and constants for the positional insert/remove array.
// ----------------------------------------------------------------------------
package pia_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int MODE_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ   = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_mode               mode;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        t_status             status;
        logic [COUNT_W-1:0]  count;
    } t_resp;

    typedef struct packed {
        t_cell_op            op;
        logic [CMP_W-1:0]    position;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/positional_insert_remove_array.sv
// ----------------------------------------------------------------------------
// positional_insert_remove_array
// Ordered fixed-capacity list held in a chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the req channel (valid/ready); each request is one
//   transaction carrying mode, position and value. Every request produces
//   exactly one response transaction on the resp channel with the element
//   read or removed, a status code and the fill count after the request.
//   Insert shifts later cells up by one, remove shifts them down by one;
//   all cells move together in the cycle the request is taken.
//   The response is registered and is valid in the cycle after the request transaction.
//   Throughput: one request per cycle when not stalled, set by the single
//   response register; the request is taken while the held response is being taken.
//   When the receiver stalls, the response register holds and o_req_ready
//   drops until it is taken, so no request is lost.
//   Reset (i_rst_n low, synchronous) empties the list and drops the response
//   valid; cell contents are not cleared and are unreadable until written.
// ----------------------------------------------------------------------------
module positional_insert_remove_array
    import pia_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_req  i_req,
    output logic  o_resp_valid,
    input  logic  i_resp_ready,
    output t_resp o_resp
);

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_resp_valid;
    logic             n_resp_valid;
    t_resp            r_resp;
    t_resp            n_resp;

    logic             w_fire;
    t_cell_ctrl       w_ctrl;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_cnt;
    logic [DATA_WIDTH-1:0] w_sel;
    logic [DATA_WIDTH-1:0] w_ins;

    assign o_req_ready = !r_resp_valid || i_resp_ready;
    assign w_fire      = i_req_valid && o_req_ready;
    assign w_pos       = CMP_W'(i_req.position);
    assign w_cnt       = CMP_W'(r_count);
    assign w_sel       = w_data[i_req.position[IDX_W-1:0]];
    assign w_ins       = i_req.value[DATA_WIDTH-1:0];

    // request decode
    always_comb begin
        n_count           = r_count;
        n_resp            = r_resp;
        w_ctrl.op         = CELL_HOLD;
        w_ctrl.position   = w_pos;
        if (w_fire) begin
            n_resp.read_value = '0;
            n_resp.status     = ST_OK;
            case (i_req.mode)
                MODE_READ: begin
                    if (w_pos >= w_cnt) begin
                        n_resp.status = ST_RANGE;
                    end else begin
                        n_resp.read_value = VALUE_W'(w_sel);
                    end
                end
                MODE_INSERT: begin
                    if (w_pos > w_cnt) begin
                        n_resp.status = ST_RANGE;
                    end else if (w_cnt >= CMP_W'(CAPACITY)) begin
                        n_resp.status = ST_FULL;
                    end else begin
                        w_ctrl.op = CELL_INSERT;
                        n_count   = r_count + CNT_W'(1);
                    end
                end
                MODE_REMOVE: begin
                    if (w_pos >= w_cnt) begin
                        n_resp.status = ST_RANGE;
                    end else begin
                        n_resp.read_value = VALUE_W'(w_sel);
                        w_ctrl.op         = CELL_REMOVE;
                        n_count           = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_count = '0;
                end
            endcase
            n_resp.count = COUNT_W'(n_count);
        end
    end

    always_comb begin
        n_resp_valid = r_resp_valid;
        if (w_fire) begin
            n_resp_valid = 1'b1;
        end else if (i_resp_ready) begin
            n_resp_valid = 1'b0;
        end
    end

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        pia_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (CMP_W'(g)),
            .i_value (w_ins),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_resp_valid <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_resp_valid <= n_resp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    assign o_resp_valid = r_resp_valid;
    assign o_resp       = r_resp;

endmodule

FILE: hw/rtl/pia_cell.sv
// ----------------------------------------------------------------------------
// pia_cell
// One storage cell of the array; loads a neighbor on insert or remove, or the new value on insert.
// ----------------------------------------------------------------------------
module pia_cell
    import pia_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [CMP_W-1:0]      i_index,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (i_index == i_ctrl.position) begin
                    n_data = i_value;
                end else if (i_index > i_ctrl.position) begin
                    n_data = i_left;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_ctrl.position) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
